### rtl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted insertion priority queue package
// Shared sizes, operation codes and status codes of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

  localparam int Depth           = 16;
  localparam int DataWidth       = 32;
  localparam int AddrWidth       = $clog2(Depth);
  localparam int CountWidth      = $clog2(Depth + 1);
  localparam int EntryCountWidth = 5;

  typedef enum logic {
    OpPush = 1'b0,
    OpPop  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

endpackage

`default_nettype wire

### rtl/sipq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/sorted_insert_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted insertion priority queue
// Keeps signed values in ascending order in a RAM; a push inserts after equal
// values and a pop removes the smallest value.
// ----------------------------------------------------------------------------
//
//   Port group     Direction  Signals
//   input item     in         in_valid_i, in_ready_o, operation_i, value_i
//   result item    out        out_valid_o, out_ready_i, popped_value_o,
//                             status_o, entry_count_o
//
// A push into a non-empty store shifts each stored value greater than the new
// one up by one entry; into an empty store, the value is written directly.
// A pop shifts the remaining values down; refused operations do no RAM walk.
// One comparator and one RAM read port walk the store one entry per cycle.
// Reset empties the store at once; no clearing pass is needed.
// The input is not ready while an operation is in progress, and the result
// stage holds a result until the output transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_priority_queue_unit (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output      logic                                    in_ready_o,
  input  wire logic                                    operation_i,
  input  wire logic signed [sipq_pkg::DataWidth-1:0]   value_i,
  output      logic                                    out_valid_o,
  input  wire logic                                    out_ready_i,
  output      logic signed [sipq_pkg::DataWidth-1:0]   popped_value_o,
  output      logic [1:0]                              status_o,
  output      logic [sipq_pkg::EntryCountWidth-1:0]    entry_count_o
);

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StPushCmp = 6'b000010,
    StPushPut = 6'b000100,
    StPopHead = 6'b001000,
    StPopShft = 6'b010000,
    StResp    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [sipq_pkg::CountWidth-1:0] count_q, count_d;
  logic [sipq_pkg::AddrWidth-1:0]  idx_q, idx_d;
  logic [sipq_pkg::DataWidth-1:0]  val_q, val_d;
  logic [sipq_pkg::DataWidth-1:0]  res_popped_q, res_popped_d;
  sipq_pkg::status_e               res_status_q, res_status_d;

  logic                                 out_valid_q, out_valid_d;
  logic [sipq_pkg::DataWidth-1:0]       out_popped_q, out_popped_d;
  sipq_pkg::status_e                    out_status_q, out_status_d;
  logic [sipq_pkg::EntryCountWidth-1:0] out_count_q, out_count_d;

  logic                            ram_we;
  logic [sipq_pkg::AddrWidth-1:0]  ram_waddr;
  logic [sipq_pkg::DataWidth-1:0]  ram_wdata;
  logic [sipq_pkg::AddrWidth-1:0]  ram_raddr;
  logic [sipq_pkg::DataWidth-1:0]  ram_rdata;

  logic                            in_xfer;
  logic                            greater;
  logic                            out_free;
  logic [sipq_pkg::CountWidth-1:0] count_m1;

  sipq_ram #(
    .Width(sipq_pkg::DataWidth),
    .Depth(sipq_pkg::Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign count_m1   = count_q - 1'b1;
  assign greater    = $signed(ram_rdata) > $signed(val_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    val_d        = val_q;
    res_popped_d = res_popped_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_popped_d = out_popped_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = val_q;
    ram_raddr    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          val_d        = value_i;
          res_popped_d = '0;
          res_status_d = sipq_pkg::StatusOk;
          if (operation_i == sipq_pkg::OpPush) begin
            if (count_q == sipq_pkg::CountWidth'(sipq_pkg::Depth)) begin
              res_status_d = sipq_pkg::StatusFull;
              state_d      = StResp;
            end else if (count_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = value_i;
              count_d   = count_q + 1'b1;
              state_d   = StResp;
            end else begin
              ram_raddr = sipq_pkg::AddrWidth'(count_m1);
              idx_d     = sipq_pkg::AddrWidth'(count_q);
              state_d   = StPushCmp;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = sipq_pkg::StatusEmpty;
              state_d      = StResp;
            end else begin
              ram_raddr = '0;
              state_d   = StPopHead;
            end
          end
        end
      end
      StPushCmp: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        if (greater) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q - 1'b1;
          ram_raddr = idx_q - 2'd2;
          if (idx_q == sipq_pkg::AddrWidth'(1)) begin
            state_d = StPushPut;
          end
        end else begin
          ram_wdata = val_q;
          count_d   = count_q + 1'b1;
          state_d   = StResp;
        end
      end
      StPushPut: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = val_q;
        count_d   = count_q + 1'b1;
        state_d   = StResp;
      end
      StPopHead: begin
        res_popped_d = ram_rdata;
        if (count_q == sipq_pkg::CountWidth'(1)) begin
          count_d = '0;
          state_d = StResp;
        end else begin
          ram_raddr = sipq_pkg::AddrWidth'(1);
          idx_d     = sipq_pkg::AddrWidth'(1);
          state_d   = StPopShft;
        end
      end
      StPopShft: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - 1'b1;
        ram_wdata = ram_rdata;
        if (idx_q == sipq_pkg::AddrWidth'(count_m1)) begin
          count_d = count_m1;
          state_d = StResp;
        end else begin
          ram_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end
      StResp: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_popped_d = res_popped_q;
          out_status_d = res_status_q;
          out_count_d  = sipq_pkg::EntryCountWidth'(count_q);
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    res_popped_q <= res_popped_d;
    res_status_q <= res_status_d;
    out_popped_q <= out_popped_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_popped_q;
  assign status_o       = out_status_q;
  assign entry_count_o  = out_count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sipq_pkg::CountWidth'(sipq_pkg::Depth))
    else $error("Entry count exceeds the store depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (sipq_pkg::CountWidth'(ram_waddr) <= count_q))
    else $error("RAM write lands beyond the occupied entries.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (operation_i == sipq_pkg::OpPush) &&
    (count_q == sipq_pkg::CountWidth'(sipq_pkg::Depth))
    |=> (state_q == StResp) && (res_status_q == sipq_pkg::StatusFull) &&
        (count_q == sipq_pkg::CountWidth'(sipq_pkg::Depth)))
    else $error("Push into a full store was not refused.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResp) && out_free |=> out_valid_q && (state_q == StIdle))
    else $error("Finished result was not loaded into the output stage.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sipq_pkg::StatusEmpty)
    |-> (popped_value_o == '0) && (entry_count_o == '0))
    else $error("Refused pop reports a value or a nonzero count.");

endmodule

`default_nettype wire

### test/sorted_insert_priority_queue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted insertion priority queue testbench
// Drives pushes and pops through the valid/ready input channel and checks
// every result against a software model of the sorted store, or against the
// fixed result of a directed row. A directed table covers the empty pop, the
// full push, the value extremes and equal values. Random traffic then follows,
// with push-heavy and pop-heavy stretches and with random idling on both sides.
// ----------------------------------------------------------------------------

module sorted_insert_priority_queue_unit_test;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 25;
  localparam int RandomItems   = 750;
  localparam int PhaseCount    = 4;

  typedef logic signed [sipq_pkg::DataWidth-1:0] word_t;

  typedef struct packed {
    word_t                                popped;
    sipq_pkg::status_e                    status;
    logic [sipq_pkg::EntryCountWidth-1:0] count;
  } queue_result_t;

  typedef struct {
    sipq_pkg::op_e op;
    word_t         value;
    bit            fixed;
    queue_result_t result;
  } stim_row_t;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_ready_o;
  logic                                 operation_i = sipq_pkg::OpPush;
  word_t                                value_i     = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  word_t                                popped_value_o;
  logic [1:0]                           status_o;
  logic [sipq_pkg::EntryCountWidth-1:0] entry_count_o;

  bit            row_fixed  = 1'b0;
  queue_result_t row_result = '0;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned error_count        = 0;
  int unsigned quiet_cycles       = 0;

  word_t         sorted_store[$];
  queue_result_t expected_results[$];
  stim_row_t     directed_rows[$];

  sorted_insert_priority_queue_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic queue_result_t apply_operation(input sipq_pkg::op_e op,
                                                    input word_t value);
    queue_result_t res;
    int            pos;
    res.popped = '0;
    res.status = sipq_pkg::StatusOk;
    if (op == sipq_pkg::OpPush) begin
      if (sorted_store.size() >= sipq_pkg::Depth) begin
        res.status = sipq_pkg::StatusFull;
      end else begin
        pos = 0;
        while (pos < sorted_store.size() && sorted_store[pos] <= value) pos++;
        sorted_store.insert(pos, value);
      end
    end else begin
      if (sorted_store.size() == 0) begin
        res.status = sipq_pkg::StatusEmpty;
      end else begin
        res.popped = sorted_store.pop_front();
      end
    end
    res.count = sipq_pkg::EntryCountWidth'(sorted_store.size());
    return res;
  endfunction

  function automatic void add_row(input sipq_pkg::op_e op, input word_t value,
                                  input bit fixed, input word_t popped,
                                  input sipq_pkg::status_e status, input int count);
    stim_row_t row;
    row.op            = op;
    row.value         = value;
    row.fixed         = fixed;
    row.result.popped = popped;
    row.result.status = status;
    row.result.count  = sipq_pkg::EntryCountWidth'(count);
    directed_rows.push_back(row);
  endfunction

  function automatic word_t random_word();
    word_t w;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: w = 32'sh7fff_ffff;
          1: w = 32'sh8000_0000;
          2: w = '0;
          default: w = '1;
        endcase
      end
      1: w = word_t'($urandom_range(8)) - 4;
      default: w = word_t'($urandom);
    endcase
    return w;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    queue_result_t exp_res;
    queue_result_t model_res;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation pending");
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (popped_value_o !== exp_res.popped) begin
            $error("popped_value: expected %0d, got %0d", exp_res.popped, popped_value_o);
            error_count++;
          end
          if (status_o !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status_o);
            error_count++;
          end
          if (entry_count_o !== exp_res.count) begin
            $error("entry_count: expected %0d, got %0d", exp_res.count, entry_count_o);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        model_res = apply_operation(sipq_pkg::op_e'(operation_i), value_i);
        expected_results.push_back(row_fixed ? row_result : model_res);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("** sorted_insert_priority_queue_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic send_operation(input sipq_pkg::op_e op, input word_t value,
                                input bit fixed, input queue_result_t fixed_result);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= value;
    row_fixed   <= fixed;
    row_result  <= fixed_result;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned   push_pct;
    int unsigned   phase_items;
    sipq_pkg::op_e op;

    add_row(sipq_pkg::OpPop,  '0,             1'b1, '0,             sipq_pkg::StatusEmpty, 0);
    add_row(sipq_pkg::OpPush, 32'sh7fff_ffff, 1'b1, '0,             sipq_pkg::StatusOk,    1);
    add_row(sipq_pkg::OpPush, 32'sh8000_0000, 1'b1, '0,             sipq_pkg::StatusOk,    2);
    add_row(sipq_pkg::OpPush, '0,             1'b0, '0,             sipq_pkg::StatusOk,    0);
    add_row(sipq_pkg::OpPop,  '0,             1'b1, 32'sh8000_0000, sipq_pkg::StatusOk,    2);
    add_row(sipq_pkg::OpPop,  32'sh5555_aaaa, 1'b0, '0,             sipq_pkg::StatusOk,    0);
    add_row(sipq_pkg::OpPop,  '0,             1'b1, 32'sh7fff_ffff, sipq_pkg::StatusOk,    0);
    add_row(sipq_pkg::OpPop,  '1,             1'b1, '0,             sipq_pkg::StatusEmpty, 0);
    for (int i = 0; i < sipq_pkg::Depth; i++) begin
      add_row(sipq_pkg::OpPush, word_t'(i % 3) - 1, 1'b0, '0, sipq_pkg::StatusOk, 0);
    end
    add_row(sipq_pkg::OpPush, 32'sh7fff_ffff, 1'b1, '0, sipq_pkg::StatusFull,
            sipq_pkg::Depth);
    add_row(sipq_pkg::OpPop,  '0,             1'b0, '0, sipq_pkg::StatusOk,   0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_operation(directed_rows[i].op, directed_rows[i].value,
                     directed_rows[i].fixed, directed_rows[i].result);
    end
    wait_for_results();

    phase_items = RandomItems / PhaseCount;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      push_pct = 50;
      for (int n = 0; n < phase_items; n++) begin
        if (n % 30 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 15;
          endcase
        end
        op = ($urandom_range(99) < push_pct) ? sipq_pkg::OpPush : sipq_pkg::OpPop;
        send_operation(op, random_word(), 1'b0, '0);
      end
      wait_for_results();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** sorted_insert_priority_queue_unit: PASSED **");
    end else begin
      $display("** sorted_insert_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
